// ----- hw/rtl/u2a_pkg.sv -----
// Package for the UTF-8 to Algol character decoder.
// It holds the prefix state codes, status codes, the decode result type and the decode function.
// It depends on nothing else.
package u2a_pkg;

    // Pending UTF-8 prefix codes. Encodings above ST_E2_8F act as idle.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_C2    = 4'd1;
    localparam logic [3:0] ST_C3    = 4'd2;
    localparam logic [3:0] ST_E2    = 4'd3;
    localparam logic [3:0] ST_E2_86 = 4'd4;
    localparam logic [3:0] ST_E2_88 = 4'd5;
    localparam logic [3:0] ST_E2_89 = 4'd6;
    localparam logic [3:0] ST_E2_8A = 4'd7;
    localparam logic [3:0] ST_E2_8F = 4'd8;

    // Result status codes.
    localparam logic [1:0] STAT_CHAR = 2'd0;
    localparam logic [1:0] STAT_END  = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    localparam logic [7:0] END_CODE = 8'd255;

    typedef struct packed {
        logic       has_result;
        logic [1:0] status;
        logic [7:0] value;
        logic [3:0] next_state;
    } decode_t;

    // Decodes one byte in the given prefix state.
    function automatic decode_t decode(input logic [3:0] state, input logic [7:0] b,
                                       input logic eoi);
        decode_t    d;
        logic       hit;
        logic [7:0] code;
        logic       pend;
        logic [3:0] nxt;
        hit  = 1'b1;
        code = 8'd0;
        pend = 1'b0;
        nxt  = ST_IDLE;
        if (eoi)
        begin
            code = END_CODE;
        end
        else
        begin
            case (state)
                ST_C2:
                begin
                    hit  = (b == 8'hAC);
                    code = 8'd76;
                end
                ST_C3:
                begin
                    if (b == 8'h97)
                        code = 8'd66;
                    else if (b == 8'hB7)
                        code = 8'd68;
                    else
                        hit = 1'b0;
                end
                ST_E2:
                begin
                    pend = 1'b1;
                    case (b)
                        8'h86:   nxt = ST_E2_86;
                        8'h88:   nxt = ST_E2_88;
                        8'h89:   nxt = ST_E2_89;
                        8'h8A:   nxt = ST_E2_8A;
                        8'h8F:   nxt = ST_E2_8F;
                        default:
                        begin
                            pend = 1'b0;
                            hit  = 1'b0;
                        end
                    endcase
                end
                ST_E2_86:
                begin
                    hit  = (b == 8'h91);
                    code = 8'd69;
                end
                ST_E2_88:
                begin
                    if (b == 8'hA7)
                        code = 8'd77;
                    else if (b == 8'hA8)
                        code = 8'd78;
                    else
                        hit = 1'b0;
                end
                ST_E2_89:
                begin
                    case (b)
                        8'hA0:   code = 8'd75;
                        8'hA1:   code = 8'd80;
                        8'hA4:   code = 8'd73;
                        8'hA5:   code = 8'd71;
                        default: hit = 1'b0;
                    endcase
                end
                ST_E2_8A:
                begin
                    hit  = (b == 8'h83);
                    code = 8'd79;
                end
                ST_E2_8F:
                begin
                    hit  = (b == 8'hA8);
                    code = 8'd89;
                end
                default:
                begin
                    // Idle, and any unused prefix encoding.
                    if (b >= 8'h30 && b <= 8'h39)
                        code = b - 8'h30;
                    else if (b >= 8'h61 && b <= 8'h7A)
                        code = b - 8'h61 + 8'd10;
                    else if (b >= 8'h41 && b <= 8'h5A)
                        code = b - 8'h41 + 8'd37;
                    else
                    begin
                        case (b)
                            8'h2B:   code = 8'd64;
                            8'h2D:   code = 8'd65;
                            8'h2A:   code = 8'd66;
                            8'h2F:   code = 8'd67;
                            8'h3E:   code = 8'd70;
                            8'h3D:   code = 8'd72;
                            8'h3C:   code = 8'd74;
                            8'h2C:   code = 8'd87;
                            8'h2E:   code = 8'd88;
                            8'h40:   code = 8'd89;
                            8'h3A:   code = 8'd90;
                            8'h3B:   code = 8'd91;
                            8'h20:   code = 8'd93;
                            8'h28:   code = 8'd98;
                            8'h29:   code = 8'd99;
                            8'h5B:   code = 8'd100;
                            8'h5D:   code = 8'd101;
                            8'h60:   code = 8'd102;
                            8'h27:   code = 8'd103;
                            8'h09:   code = 8'd118;
                            8'h0A:   code = 8'd119;
                            8'h0D:   pend = 1'b1;
                            8'h22:   code = 8'd121;
                            8'h3F:   code = 8'd122;
                            8'h7C:   code = 8'd162;
                            8'h5F:   code = 8'd163;
                            8'hC2:
                            begin
                                pend = 1'b1;
                                nxt  = ST_C2;
                            end
                            8'hC3:
                            begin
                                pend = 1'b1;
                                nxt  = ST_C3;
                            end
                            8'hE2:
                            begin
                                pend = 1'b1;
                                nxt  = ST_E2;
                            end
                            default: hit = 1'b0;
                        endcase
                    end
                end
            endcase
        end
        d.has_result = !pend;
        d.next_state = nxt;
        if (eoi)
        begin
            d.status = STAT_END;
            d.value  = END_CODE;
        end
        else if (!hit)
        begin
            d.status = STAT_BAD;
            d.value  = b;
        end
        else
        begin
            d.status = STAT_CHAR;
            d.value  = code;
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/utf8_to_algol_char_decoder.sv -----
// An accepted byte waits in the input register and is decoded against the prefix register;
// its result is then registered. Throughput: one byte per cycle unless a stalled result blocks it.
// The result register lets a new byte be taken while a finished code waits downstream.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the prefix to idle.
// File: top level of the UTF-8 to Algol character decoder; depends on u2a_pkg.
module utf8_to_algol_char_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       code_valid,
    input  logic       code_stall,
    output logic [1:0] status,
    output logic [7:0] value
);

    // Input register. The accepted transaction waits here while it is decoded.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eoi_reg;

    // Pending UTF-8 prefix. Only the item in the input register reads it, and it
    // is updated when that item leaves, so successive bytes see the right state.
    logic [3:0] prefix_reg;

    // Result register driving the output channel.
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_value_reg;

    u2a_pkg::decode_t dec;
    logic             out_free;
    logic             s1_move;
    logic             s1_load;

    always_comb
    begin
        dec = u2a_pkg::decode(prefix_reg, s1_byte_reg, s1_eoi_reg);
    end

    // The result register can take a new result when it is empty or is being drained.
    // An item that gives no result (a lead byte, an E2 second byte or a carriage return) never waits.
    assign out_free   = !out_valid_reg || !code_stall;
    assign s1_move    = s1_valid_reg && (!dec.has_result || out_free);
    assign byte_stall = s1_valid_reg && !s1_move;
    assign s1_load    = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            prefix_reg    <= u2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                prefix_reg <= dec.next_state;

            if (s1_move && dec.has_result)
                out_valid_reg <= 1'b1;
            else if (!code_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= data_byte;
            s1_eoi_reg  <= end_of_input;
        end
        if (s1_move && dec.has_result)
        begin
            out_status_reg <= dec.status;
            out_value_reg  <= dec.value;
        end
    end

    assign code_valid = out_valid_reg;
    assign status     = out_status_reg;
    assign value      = out_value_reg;

`ifndef SYNTH
    // The prefix register only ever holds a defined prefix code.
    a_prefix_defined: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_reg <= u2a_pkg::ST_E2_8F)
        else $error("prefix register holds an unused code");

    // End of input always leaves the decoder idle.
    a_end_clears_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_eoi_reg) |=> (prefix_reg == u2a_pkg::ST_IDLE))
        else $error("prefix not cleared after end of input");

    // An end-of-input result always carries the end code.
    a_end_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == u2a_pkg::STAT_END)
            |-> (out_value_reg == u2a_pkg::END_CODE))
        else $error("end result without end code");

    // A result waiting downstream is never overwritten by a decoded item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && code_stall) |-> !(s1_move && dec.has_result))
        else $error("stalled result overwritten");
`endif

endmodule

// ----- tb/sv/utf8_to_algol_char_checker.sv -----
// Checker for the UTF-8 to Algol character decoder: watches both channels, predicts each
// result from the accepted bytes and compares it with what the decoder hands out.
// Depends on u2a_pkg for the prefix state and status codes.
`timescale 1ns / 100ps
module utf8_to_algol_char_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       code_valid,
    input  logic       code_stall,
    input  logic [1:0] status,
    input  logic [7:0] value,
    output int         mismatches,
    output int         pending,
    output int         checked
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] value;
    } algol_result_t;

    // Outcomes of a byte lookup besides a real character code.
    localparam int NO_CODE  = -1;
    localparam int BAD_CODE = -2;

    algol_result_t expected_codes[$];
    logic [3:0]    prefix;
    int            mismatch_count;
    int            checked_count;
    int            pending_count;

    assign mismatches = mismatch_count;
    assign checked    = checked_count;
    assign pending    = pending_count;

    // Code of a byte that arrives with no prefix pending. Lead bytes are handled by the caller.
    function automatic int plain_code(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h7A)
            return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h5A)
            return int'(b) - 'h41 + 37;
        case (b)
            8'h2B:   return 64;
            8'h2D:   return 65;
            8'h2A:   return 66;
            8'h2F:   return 67;
            8'h3E:   return 70;
            8'h3D:   return 72;
            8'h3C:   return 74;
            8'h2C:   return 87;
            8'h2E:   return 88;
            8'h40:   return 89;
            8'h3A:   return 90;
            8'h3B:   return 91;
            8'h20:   return 93;
            8'h28:   return 98;
            8'h29:   return 99;
            8'h5B:   return 100;
            8'h5D:   return 101;
            8'h60:   return 102;
            8'h27:   return 103;
            8'h09:   return 118;
            8'h0A:   return 119;
            8'h0D:   return NO_CODE;
            8'h22:   return 121;
            8'h3F:   return 122;
            8'h7C:   return 162;
            8'h5F:   return 163;
            default: return BAD_CODE;
        endcase
    endfunction

    // Code of the final byte of a multi-byte symbol, given the prefix seen so far.
    function automatic int tail_code(input logic [3:0] st, input logic [7:0] b);
        case (st)
            u2a_pkg::ST_C2:    return (b == 8'hAC) ? 76 : BAD_CODE;
            u2a_pkg::ST_C3:    return (b == 8'h97) ? 66 : (b == 8'hB7) ? 68 : BAD_CODE;
            u2a_pkg::ST_E2_86: return (b == 8'h91) ? 69 : BAD_CODE;
            u2a_pkg::ST_E2_88: return (b == 8'hA7) ? 77 : (b == 8'hA8) ? 78 : BAD_CODE;
            u2a_pkg::ST_E2_89:
            begin
                case (b)
                    8'hA0:   return 75;
                    8'hA1:   return 80;
                    8'hA4:   return 73;
                    8'hA5:   return 71;
                    default: return BAD_CODE;
                endcase
            end
            u2a_pkg::ST_E2_8A: return (b == 8'h83) ? 79 : BAD_CODE;
            u2a_pkg::ST_E2_8F: return (b == 8'hA8) ? 89 : BAD_CODE;
            default:           return BAD_CODE;
        endcase
    endfunction

    // Advances the prefix tracker by one transaction and queues the code it produces, if any.
    task automatic predict_code(input logic [7:0] b, input logic eoi);
        logic [3:0] st;
        int         code;
        st     = prefix;
        prefix = u2a_pkg::ST_IDLE;
        code   = NO_CODE;
        if (eoi)
        begin
            expected_codes.push_back({u2a_pkg::STAT_END, u2a_pkg::END_CODE});
            return;
        end
        if (st == u2a_pkg::ST_IDLE || st > u2a_pkg::ST_E2_8F)
        begin
            case (b)
                8'hC2:   prefix = u2a_pkg::ST_C2;
                8'hC3:   prefix = u2a_pkg::ST_C3;
                8'hE2:   prefix = u2a_pkg::ST_E2;
                default: code = plain_code(b);
            endcase
        end
        else if (st == u2a_pkg::ST_E2)
        begin
            case (b)
                8'h86:   prefix = u2a_pkg::ST_E2_86;
                8'h88:   prefix = u2a_pkg::ST_E2_88;
                8'h89:   prefix = u2a_pkg::ST_E2_89;
                8'h8A:   prefix = u2a_pkg::ST_E2_8A;
                8'h8F:   prefix = u2a_pkg::ST_E2_8F;
                default: code = BAD_CODE;
            endcase
        end
        else
        begin
            code = tail_code(st, b);
        end
        if (code == BAD_CODE)
            expected_codes.push_back({u2a_pkg::STAT_BAD, b});
        else if (code != NO_CODE)
            expected_codes.push_back({u2a_pkg::STAT_CHAR, 8'(code)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        algol_result_t got;
        algol_result_t want;
        if (!rst_n)
        begin
            expected_codes.delete();
            prefix         = u2a_pkg::ST_IDLE;
            mismatch_count = 0;
            checked_count  = 0;
            pending_count  <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                predict_code(data_byte, end_of_input);
            if (code_valid && !code_stall)
            begin
                got = {status, value};
                if (expected_codes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result status %0d value %0d arrived with none expected",
                                 $time, got.status, got.value);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    checked_count++;
                    if (got.status !== want.status || got.value !== want.value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: status expected %0d got %0d, value expected %0d got %0d",
                                     $time, want.status, got.status, want.value, got.value);
                    end
                end
            end
            pending_count <= expected_codes.size();
        end
    end

endmodule

// ----- tb/sv/utf8_to_algol_char_decoder_tb.sv -----
// Testbench top for the UTF-8 to Algol character decoder: byte source, code sink and verdict.
// Depends on the decoder RTL with u2a_pkg and on utf8_to_algol_char_checker.
`timescale 1ns / 100ps
module utf8_to_algol_char_decoder_tb;

    // Length of the one long hold-off on the code channel, in clock cycles.
    localparam int LONG_HOLD_CYCLES = 200;
    // Least number of byte transactions, carriage returns apart, offered per random phase.
    localparam int PHASE_ITEMS = 212;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] data_byte;
    logic       end_of_input;
    logic       code_valid;
    logic       code_stall;
    logic [1:0] status;
    logic [7:0] value;

    int mismatches;
    int pending;
    int checked;

    // Idling controls shared between the byte source and the code sink. When a steady flag
    // is set, that side runs without any gaps; hold_request asks the sink for one long stall.
    bit tx_steady;
    bit rx_steady;
    bit hold_request;

    int bytes_sent;
    int ends_sent;

    // Every single byte that maps straight to a character code (backquote written as octal).
    string plain_chars = {"0123456789abcdefghijklmnopqrstuvwxyz",
                          "ABCDEFGHIJKLMNOPQRSTUVWXYZ+-*/>=<,.@:;()[]\140'\t\n\"?|_ "};

    // The recognized multi-byte symbols. Two-byte ones carry a zero top byte.
    logic [23:0] symbol_seqs [12] = '{24'h00C2AC, 24'h00C397, 24'h00C3B7, 24'hE28691,
                                      24'hE288A7, 24'hE288A8, 24'hE289A0, 24'hE289A1,
                                      24'hE289A4, 24'hE289A5, 24'hE28A83, 24'hE28FA8};

    utf8_to_algol_char_decoder i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .status       (status),
        .value        (value)
    );

    // The checker sees exactly what the decoder sees and reports back its counts.
    utf8_to_algol_char_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .status       (status),
        .value        (value),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one byte transaction after a random gap and returns at the edge that accepts it.
    // Valid is raised without looking at stall, and the payload stays put while stalled.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid   <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (eoi)
            ends_sent++;
        else if (b != 8'h0D)
            bytes_sent++;
    endtask

    // Sends the first count bytes of a multi-byte symbol; a count of 3 sends it whole.
    task automatic send_seq(input logic [23:0] seq, input int count);
        int first;
        first = (seq[23:16] == 8'h00) ? 1 : 0;
        for (int i = first; i < first + count && i < 3; i++)
            send_byte(seq[23 - 8 * i -: 8], 1'b0);
    endtask

    // Drops valid and waits until every queued code has come out of the decoder. The first
    // edge is always taken so that the checker has seen the last accepted transaction.
    task automatic wait_drained();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // One random token of the stream. Most tokens are well-formed characters and symbols so
    // that the deeper prefix states are exercised; the rest are carriage returns, end marks
    // (often cutting a symbol short), broken symbols and raw noise bytes.
    task automatic send_random_token();
        int          pick;
        logic [23:0] seq;
        int          cut;
        pick = $urandom_range(0, 99);
        seq  = symbol_seqs[$urandom_range(0, 11)];
        cut  = (seq[23:16] != 8'h00) ? $urandom_range(1, 2) : 1;
        if (pick < 42)
        begin
            send_byte(plain_chars[$urandom_range(0, plain_chars.len() - 1)], 1'b0);
        end
        else if (pick < 72)
        begin
            send_seq(seq, 3);
        end
        else if (pick < 76)
        begin
            send_byte(8'h0D, 1'b0);
        end
        else if (pick < 83)
        begin
            // End of input, half of the time in the middle of a symbol.
            if ($urandom_range(0, 1) == 1)
                send_seq(seq, cut);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick < 92)
        begin
            // A symbol broken off by some other byte, usually not its proper continuation.
            send_seq(seq, cut);
            if ($urandom_range(0, 1) == 1)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                send_byte(plain_chars[$urandom_range(0, plain_chars.len() - 1)], 1'b0);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Code sink. Before each code transaction it stalls for a drawn number of cycles, or for
    // the long hold-off when one is requested, then takes the next code that is offered.
    initial
    begin : code_sink
        int hold;
        code_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = hold_request ? LONG_HOLD_CYCLES : (rx_steady ? 0 : $urandom_range(0, 16));
            hold_request = 1'b0;
            if (hold > 0)
            begin
                code_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            code_stall <= 1'b0;
            @(posedge clk);
            while (!code_valid)
                @(posedge clk);
        end
    end

    initial
    begin : byte_source
        int target;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_byte    = 8'h00;
        end_of_input = 1'b0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        ends_sent    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme bytes, carriage return, one symbol of each length and
        // prefix depth, end of input in idle and mid-symbol, and symbols broken off by a
        // carriage return or an ASCII letter.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("0", 1'b0);
        send_byte("z", 1'b0);
        send_byte("Z", 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_seq(24'h00C2AC, 3);
        send_seq(24'h00C3B7, 3);
        send_seq(24'hE289A5, 3);
        send_seq(24'hE28FA8, 3);
        send_seq(24'hE28FA8, 1);
        send_byte(8'h00, 1'b1);
        send_seq(24'h00C397, 1);
        send_byte(8'h0D, 1'b0);
        send_seq(24'hE28691, 2);
        send_byte("A", 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        // Random part in phases with their own idling mix. Phase 1 runs both sides without
        // gaps; phase 2 opens with the long hold-off on the code side while bytes keep
        // coming back to back, so the decoder fills and stalls its input; phase 4 ends with
        // the source pausing until every code has been delivered.
        for (int phase = 0; phase < 8; phase++)
        begin
            tx_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
            rx_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                hold_request = 1'b1;
                tx_steady    = 1'b1;
                repeat (40)
                    send_byte(plain_chars[$urandom_range(0, plain_chars.len() - 1)], 1'b0);
                tx_steady = 1'b0;
            end
            target = bytes_sent + ends_sent + PHASE_ITEMS;
            while (bytes_sent + ends_sent < target)
                send_random_token();
            if (phase == 4)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Decoded %0d bytes and %0d end marks, %0d codes compared, with gaps, a long",
                 bytes_sent, ends_sent, checked);
        $display("output hold-off and drained pauses on both channels.");
        if (mismatches == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake; a correct run needs well under a tenth of this.
    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
